### sv/rtcm_pkg.sv
`default_nettype none

package rtcm_pkg;

  // request kinds carried in the input tuser
  localparam logic [2:0] REQ_TICK     = 3'd0;
  localparam logic [2:0] REQ_READ     = 3'd1;
  localparam logic [2:0] REQ_SET      = 3'd2;
  localparam logic [2:0] REQ_HALT_RD  = 3'd3;
  localparam logic [2:0] REQ_HALT     = 3'd4;
  localparam logic [2:0] REQ_TRICKLE  = 3'd5;
  // internal first step of a time set
  localparam logic [2:0] REQ_WP_CLEAR = 3'd6;

  // data line codes
  localparam logic [1:0] IO_LOW  = 2'd0;
  localparam logic [1:0] IO_HIGH = 2'd1;
  localparam logic [1:0] IO_REL  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;
  localparam logic [1:0] ST_REJ  = 2'd3;

  // configuration register indexes
  localparam logic CFG_TRICKLE = 1'b0;
  localparam logic CFG_HALF    = 1'b1;

  localparam logic [7:0] TRICKLE_RESET = 8'hA5;
  localparam logic [7:0] HALF_RESET    = 8'd1;

  // chip command bytes
  localparam logic [7:0] ADDR_BURST   = 8'hBE;
  localparam logic [7:0] ADDR_WP      = 8'h8E;
  localparam logic [7:0] ADDR_TRICKLE = 8'h90;
  localparam logic [7:0] ADDR_SECONDS = 8'h80;
  localparam logic [7:0] CMD_READ     = 8'b1000_0001;
  localparam logic [7:0] CMD_WRITE    = 8'b1000_0000;
  localparam logic [7:0] HALT_BYTE    = 8'h80;
  localparam logic [7:0] PROTECT_BYTE = 8'h80;

  // decode masks
  localparam logic [7:0] MASK_7F = 8'b0111_1111;
  localparam logic [7:0] MASK_3F = 8'b0011_1111;
  localparam logic [7:0] MASK_1F = 8'b0001_1111;
  localparam logic [7:0] MASK_07 = 8'b0000_0111;

  localparam int unsigned TDATA_IN_W  = 40;
  localparam int unsigned TUSER_IN_W  = 3;
  localparam int unsigned TDATA_OUT_W = 48;
  localparam int unsigned TUSER_OUT_W = 2;

  typedef struct packed {
    logic [2:0] req_type;
    logic       io_in;
    logic [5:0] set_seconds;
    logic [5:0] set_minutes;
    logic [4:0] set_hours;
    logic [4:0] set_day_of_month;
    logic [3:0] set_month;
    logic [2:0] set_weekday;
    logic [7:0] set_year;
  } rtcm_item_t;

  typedef struct packed {
    logic              chip_enable;
    logic              serial_clock;
    logic [1:0]        io_pin;
    logic [1:0]        status;
    logic              halted;
    logic [6:0]        seconds;
    logic [6:0]        minutes;
    logic [5:0]        hours;
    logic [5:0]        day_of_month;
    logic signed [5:0] month;
    logic [2:0]        weekday;
    logic [7:0]        year;
  } rtcm_res_t;

  // binary to two bcd digits, value below 100; tens by reciprocal multiply
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    prod = 15'(v) * 15'd205;
    tens = prod[14:11];
    ones = v - 7'(7'({3'b000, tens}) * 7'd10);
    return {tens, ones[3:0]};
  endfunction

  // masked bcd byte to binary; mask always clears bit 7
  function automatic logic [6:0] from_bcd(input logic [7:0] b, input logic [7:0] mask);
    logic [7:0] m;
    m = b & mask;
    return 7'(7'({4'b0000, m[6:4]}) * 7'd10) + 7'({3'b000, m[3:0]});
  endfunction

endpackage

`default_nettype wire

### sv/rtcm_core.sv
`default_nettype none

module rtcm_core import rtcm_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire rtcm_item_t item_i,
  input  wire logic [7:0] trickle_i,
  input  wire logic [7:0] half_i,
  output rtcm_res_t       res_o
);

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_LOW   = 3'd1;
  localparam logic [2:0] PH_HIGH  = 3'd2;
  localparam logic [2:0] PH_END   = 3'd3;
  localparam logic [2:0] PH_START = 3'd4;

  logic [2:0] act_q, act_d;
  logic [2:0] phase_q, phase_d;
  logic [3:0] byte_idx_q, byte_idx_d;
  logic [2:0] bit_idx_q, bit_idx_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] tick_q, tick_d;
  logic       ce_q, ce_d;
  logic       clk_q, clk_d;
  logic [1:0] io_q, io_d;
  logic [7:0] store_q [1:8];
  logic [7:0] store_d [1:8];

  function automatic logic is_read(input logic [2:0] r);
    return (r == REQ_READ) || (r == REQ_HALT_RD);
  endfunction

  function automatic logic [3:0] data_count(input logic [2:0] r);
    logic [3:0] n;
    n = 4'd1;
    if (r == REQ_READ) n = 4'd7;
    else if (r == REQ_SET) n = 4'd8;
    return n;
  endfunction

  function automatic logic [7:0] command_for(input logic [2:0] r);
    logic [7:0] c;
    unique case (r)
      REQ_READ:    c = CMD_READ | ADDR_BURST;
      REQ_SET:     c = CMD_WRITE | ADDR_BURST;
      REQ_HALT_RD: c = CMD_READ | ADDR_SECONDS;
      REQ_HALT:    c = CMD_WRITE | ADDR_SECONDS;
      REQ_TRICKLE: c = CMD_WRITE | ADDR_TRICKLE;
      default:     c = CMD_WRITE | ADDR_WP;
    endcase
    return c;
  endfunction

  logic       is_req;
  logic       rd_cur;
  logic       start;
  logic [2:0] start_act;
  logic       done;
  logic [1:0] status;
  logic [7:0] shift_nx;
  logic [3:0] byte_nx;
  logic [6:0] v_sec, v_min, v_day, v_mon, v_year;
  logic [4:0] v_hour;
  logic [6:0] d_mon, d_wday;
  logic [7:0] cmd;

  // reduced set-time values
  always_comb begin
    v_sec  = (item_i.set_seconds >= 6'd60) ? 7'(item_i.set_seconds - 6'd60)
                                            : 7'(item_i.set_seconds);
    v_min  = (item_i.set_minutes >= 6'd60) ? 7'(item_i.set_minutes - 6'd60)
                                            : 7'(item_i.set_minutes);
    v_hour = (item_i.set_hours >= 5'd24) ? item_i.set_hours - 5'd24 : item_i.set_hours;
    v_day  = 7'(item_i.set_day_of_month);
    v_mon  = 7'(item_i.set_month) + 7'd1;
    if (v_mon >= 7'd13) v_mon = v_mon - 7'd13;
    if (item_i.set_year >= 8'd200)      v_year = 7'(item_i.set_year - 8'd200);
    else if (item_i.set_year >= 8'd100) v_year = 7'(item_i.set_year - 8'd100);
    else                                v_year = 7'(item_i.set_year);
  end

  always_comb begin
    act_d      = act_q;
    phase_d    = phase_q;
    byte_idx_d = byte_idx_q;
    bit_idx_d  = bit_idx_q;
    shift_d    = shift_q;
    tick_d     = tick_q;
    ce_d       = ce_q;
    clk_d      = clk_q;
    io_d       = io_q;
    store_d    = store_q;
    start      = 1'b0;
    start_act  = act_q;
    done       = 1'b0;
    status     = ST_BUSY;
    shift_nx   = shift_q;
    byte_nx    = byte_idx_q;
    cmd        = '0;
    rd_cur     = (byte_idx_q != 4'd0) && is_read(act_q);
    is_req     = (item_i.req_type >= REQ_READ) && (item_i.req_type <= REQ_TRICKLE);

    if (is_req) begin
      if (phase_q != PH_IDLE) begin
        status = ST_REJ;
      end else begin
        start = 1'b1;
        if (item_i.req_type == REQ_SET) begin
          store_d[1] = to_bcd(v_sec);
          store_d[2] = to_bcd(v_min);
          store_d[3] = to_bcd(7'(v_hour));
          store_d[4] = to_bcd(v_day);
          store_d[5] = to_bcd(v_mon);
          store_d[6] = to_bcd((item_i.set_weekday == 3'd0) ? 7'd7 : 7'(item_i.set_weekday));
          store_d[7] = to_bcd(v_year);
          store_d[8] = PROTECT_BYTE;
          start_act  = REQ_WP_CLEAR;
        end else begin
          if (item_i.req_type == REQ_HALT)    store_d[1] = HALT_BYTE;
          if (item_i.req_type == REQ_TRICKLE) store_d[1] = trickle_i;
          start_act = item_i.req_type;
        end
      end
    end else if (phase_q == PH_IDLE) begin
      status = ST_IDLE;
    end else if (tick_q < half_i) begin
      tick_d = tick_q + 8'd1;
    end else begin
      unique case (phase_q)
        PH_LOW: begin
          if (rd_cur) shift_d = {item_i.io_in, shift_q[7:1]};
          clk_d   = 1'b1;
          phase_d = PH_HIGH;
          tick_d  = 8'd1;
        end
        PH_HIGH: begin
          clk_d    = 1'b0;
          tick_d   = 8'd1;
          phase_d  = PH_LOW;
          shift_nx = rd_cur ? shift_q : {1'b0, shift_q[7:1]};
          if (bit_idx_q == 3'd7) begin
            bit_idx_d = 3'd0;
            if (rd_cur) store_d[byte_idx_q] = shift_q;
            if (byte_idx_q >= data_count(act_q)) begin
              phase_d = PH_END;
            end else begin
              byte_nx  = byte_idx_q + 4'd1;
              shift_nx = (is_read(act_q) || act_q == REQ_WP_CLEAR) ? 8'd0 : store_q[byte_nx];
            end
          end else begin
            bit_idx_d = bit_idx_q + 3'd1;
          end
          shift_d    = shift_nx;
          byte_idx_d = byte_nx;
          if (phase_d == PH_LOW) begin
            io_d = ((byte_nx != 4'd0) && is_read(act_q)) ? IO_REL : {1'b0, shift_nx[0]};
          end
        end
        PH_END: begin
          ce_d  = 1'b0;
          clk_d = 1'b0;
          io_d  = IO_REL;
          if (act_q == REQ_WP_CLEAR) begin
            act_d   = REQ_SET;
            phase_d = PH_START;
            tick_d  = 8'd1;
          end else begin
            done = 1'b1;
          end
        end
        default: begin
          start = 1'b1;
        end
      endcase
    end

    // open a transfer with the command byte
    if (start) begin
      cmd        = command_for(start_act);
      act_d      = start_act;
      byte_idx_d = 4'd0;
      bit_idx_d  = 3'd0;
      shift_d    = cmd;
      ce_d       = 1'b1;
      clk_d      = 1'b0;
      io_d       = {1'b0, cmd[0]};
      phase_d    = PH_LOW;
      tick_d     = 8'd1;
    end

    if (done) begin
      act_d      = REQ_TICK;
      phase_d    = PH_IDLE;
      byte_idx_d = 4'd0;
      bit_idx_d  = 3'd0;
      tick_d     = 8'd0;
      status     = ST_DONE;
    end
  end

  // result assembly
  always_comb begin
    d_mon  = from_bcd(store_q[5], MASK_1F) - 7'd1;
    d_wday = from_bcd(store_q[6], MASK_07);
    res_o              = '0;
    res_o.chip_enable  = ce_d;
    res_o.serial_clock = clk_d;
    res_o.io_pin       = io_d;
    res_o.status       = status;
    if (done && act_q == REQ_HALT_RD) begin
      res_o.halted = store_q[1][7];
    end
    if (done && act_q == REQ_READ) begin
      res_o.seconds      = from_bcd(store_q[1], MASK_7F);
      res_o.minutes      = from_bcd(store_q[2], MASK_7F);
      res_o.hours        = 6'(from_bcd(store_q[3], MASK_3F));
      res_o.day_of_month = 6'(from_bcd(store_q[4], MASK_3F));
      res_o.month        = 6'(d_mon);
      res_o.weekday      = (d_wday == 7'd7) ? 3'd0 : 3'(d_wday);
      res_o.year         = 8'd100 + 8'(from_bcd(store_q[7], MASK_7F));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q      <= REQ_TICK;
      phase_q    <= PH_IDLE;
      byte_idx_q <= '0;
      bit_idx_q  <= '0;
      shift_q    <= '0;
      tick_q     <= '0;
      ce_q       <= 1'b0;
      clk_q      <= 1'b0;
      io_q       <= IO_REL;
    end else if (step_i) begin
      act_q      <= act_d;
      phase_q    <= phase_d;
      byte_idx_q <= byte_idx_d;
      bit_idx_q  <= bit_idx_d;
      shift_q    <= shift_d;
      tick_q     <= tick_d;
      ce_q       <= ce_d;
      clk_q      <= clk_d;
      io_q       <= io_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) store_q <= store_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (!ce_q && !clk_q && io_q == IO_REL))
    else $error("lines not parked while idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clk_q |-> (phase_q == PH_HIGH && ce_q))
    else $error("serial clock high outside a high half period");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((phase_q == PH_LOW || phase_q == PH_HIGH) && byte_idx_q != 4'd0 && is_read(act_q))
    |-> (io_q == IO_REL))
    else $error("data line driven during read data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_IDLE) |-> (tick_q != 8'd0 && byte_idx_q <= 4'd8))
    else $error("bit timing state out of range");

endmodule

`default_nettype wire

### sv/three_wire_rtc_bus_master.sv
// channel   direction  handshake                payload
// s_axis    in         s_axis_tvalid/tready     tuser: request kind, tdata: io level, set time
// m_axis    out        m_axis_tvalid/tready     tuser: status, tdata: line levels, read time
// cfg       in         cfg_valid/cfg_ready      cfg_index_i, cfg_data_i
//
// one result per request or tick; an item passes an input register and then the
// transaction step logic into the result register, whose valid drives tvalid
// one item per cycle with m_axis_tready high; the step logic is a single pass over the item
// reset clears the bit sequencer and parks the lines: chip enable low, data released
// an output stall fills the input register and then drops s_axis_tready
// cfg_ready_o is always high; the user must write registers only while no transaction is open, unchecked by the block

`default_nettype none

module three_wire_rtc_bus_master import rtcm_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // request and tick items
  input  wire logic                   s_axis_tvalid,
  output      logic                   s_axis_tready,
  // [0] io_in, [6:1] set_seconds, [12:7] set_minutes, [17:13] set_hours,
  // [22:18] set_day_of_month, [26:23] set_month, [29:27] set_weekday, [37:30] set_year
  input  wire logic [TDATA_IN_W-1:0]  s_axis_tdata,
  // [2:0] req_type
  input  wire logic [TUSER_IN_W-1:0]  s_axis_tuser,
  // results
  output      logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // [0] chip_enable, [1] serial_clock, [3:2] io_pin, [4] halted, [11:5] seconds,
  // [18:12] minutes, [24:19] hours, [30:25] day_of_month, [36:31] month,
  // [39:37] weekday, [47:40] year
  output      logic [TDATA_OUT_W-1:0] m_axis_tdata,
  // [1:0] status
  output      logic [TUSER_OUT_W-1:0] m_axis_tuser,
  // configuration writes
  input  wire logic                   cfg_valid_i,
  output      logic                   cfg_ready_o,
  input  wire logic                   cfg_index_i,
  input  wire logic [7:0]             cfg_data_i
);

  // configuration registers
  logic [7:0] trickle_q;
  logic [7:0] half_q;

  // input stage
  logic       in_valid_q;
  rtcm_item_t in_item_q;
  rtcm_item_t in_item_d;

  // result stage
  logic                   out_valid_q;
  logic [TDATA_OUT_W-1:0] out_tdata_q, out_tdata_d;
  logic [TUSER_OUT_W-1:0] out_tuser_q;

  rtcm_res_t res;
  logic      advance;

  // the input item moves on when the result register is free or being drained
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    in_item_d.req_type         = s_axis_tuser[2:0];
    in_item_d.io_in            = s_axis_tdata[0];
    in_item_d.set_seconds      = s_axis_tdata[6:1];
    in_item_d.set_minutes      = s_axis_tdata[12:7];
    in_item_d.set_hours        = s_axis_tdata[17:13];
    in_item_d.set_day_of_month = s_axis_tdata[22:18];
    in_item_d.set_month        = s_axis_tdata[26:23];
    in_item_d.set_weekday      = s_axis_tdata[29:27];
    in_item_d.set_year         = s_axis_tdata[37:30];
  end

  rtcm_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .item_i    (in_item_q),
    .trickle_i (trickle_q),
    .half_i    (half_q),
    .res_o     (res)
  );

  // pack the result, lowest field first
  assign out_tdata_d = {res.year, res.weekday, res.month, res.day_of_month, res.hours,
                        res.minutes, res.seconds, res.halted, res.io_pin,
                        res.serial_clock, res.chip_enable};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trickle_q <= TRICKLE_RESET;
      half_q    <= HALF_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_TRICKLE) trickle_q <= cfg_data_i;
      else if (cfg_index_i == CFG_HALF) half_q <= cfg_data_i;
    end
  end

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) in_item_q <= in_item_d;
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_tdata_q <= out_tdata_d;
      out_tuser_q <= res.status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_tdata_q;
  assign m_axis_tuser  = out_tuser_q;

endmodule

`default_nettype wire
